// ===== hdl/viqs_pkg.sv =====
// Package with the types and constants of the vector issue queue select unit.
`default_nettype none
package viqs_pkg;

   localparam int ARITH_DEPTH = 16;
   localparam int MEM_DEPTH   = 16;
   localparam int NUM_PREGS   = 64;
   localparam int AIDX_W      = $clog2(ARITH_DEPTH);
   localparam int MIDX_W      = $clog2(MEM_DEPTH);
   localparam int ACNT_W      = $clog2(ARITH_DEPTH + 1);
   localparam int MCNT_W      = $clog2(MEM_DEPTH + 1);
   localparam int PREG_W      = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_OOO_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARITH_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_LIMIT  = 2'd2;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_PUSH_ARITH = 3'd1,
      OP_PUSH_MEM   = 3'd2,
      OP_MARK_READY = 3'd3,
      OP_MARK_BUSY  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ASCAN,
      ST_AMOVE,
      ST_MSCAN,
      ST_MMOVE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [7:0]        tag;
      logic [PREG_W-1:0] preg_first;
      logic [PREG_W-1:0] preg_second;
      logic [PREG_W-1:0] preg_third;
      logic [PREG_W-1:0] preg_mask;
      logic              is_masked;
      logic              scalar_first;
      logic [1:0]        vector_sources;
      logic              is_store;
      logic              is_indexed;
      logic [1:0]        units_free;
   } req_type;

   typedef struct packed {
      logic       arith_issued;
      logic [7:0] arith_tag_out;
      logic       mem_issued;
      logic [7:0] mem_tag_out;
      logic       arith_full;
      logic       mem_full;
      logic       push_dropped;
   } rsp_type;

   typedef struct packed {
      logic [7:0]        tag;
      logic [PREG_W-1:0] first;
      logic [PREG_W-1:0] second;
      logic [PREG_W-1:0] third;
      logic [PREG_W-1:0] maskreg;
      logic              masked;
      logic              scalar;
      logic [1:0]        nsrc;
   } aent_type;

   typedef struct packed {
      logic [7:0]        tag;
      logic [PREG_W-1:0] second;
      logic [PREG_W-1:0] third;
      logic              store;
      logic              indexed;
   } ment_type;

endpackage
`default_nettype wire

// ===== hdl/viqs_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
`default_nettype none
module viqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/vector_issue_queue_select_unit.sv =====
// Top level: two issue queues in RAM with an oldest-ready select sequencer.
// Timing: a push or mark item holds busy for one cycle, in the done state that is
// registered on acceptance; its result strobe is registered from that state. A tick
// reads each entry checked and each entry moved down when closing the gap, first in
// the arith queue, then in the mem queue, before the done state. One transaction is
// in flight at a time; the receiver cannot stall. Synchronous reset empties both
// queues, marks every register ready and restores the configuration reset values.
`default_nettype none
module vector_issue_queue_select_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire viqs_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   output viqs_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [viqs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [viqs_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import viqs_pkg::*;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [ACNT_W-1:0] acount_ff, acount_in;
   logic [MCNT_W-1:0] mcount_ff, mcount_in;
   logic [NUM_PREGS-1:0] ready_ff, ready_in;
   logic      ooo_ff;
   logic [CSR_DATA_W-1:0] alimit_ff, mlimit_ff;
   // Scan position; 7 bits against a 4-bit index, so the move loop can reach count.
   logic [6:0] pos_ff, pos_in;
   logic       rd_wait_ff, rd_wait_in;

   logic [AIDX_W-1:0] a_wr_addr, a_rd_addr;
   logic [MIDX_W-1:0] m_wr_addr, m_rd_addr;
   logic a_wr_en, m_wr_en;
   aent_type a_wr_data, a_rd_data;
   ment_type m_wr_data, m_rd_data;

   viqs_ram #(.WIDTH($bits(aent_type)), .DEPTH(ARITH_DEPTH)) u_aram (
      .clock(clock), .wr_en(a_wr_en), .wr_addr(a_wr_addr), .wr_data(a_wr_data),
      .rd_addr(a_rd_addr), .rd_data(a_rd_data));
   viqs_ram #(.WIDTH($bits(ment_type)), .DEPTH(MEM_DEPTH)) u_mram (
      .clock(clock), .wr_en(m_wr_en), .wr_addr(m_wr_addr), .wr_data(m_wr_data),
      .rd_addr(m_rd_addr), .rd_data(m_rd_data));

   function automatic logic rdy(input logic [NUM_PREGS-1:0] tbl,
                                input logic [PREG_W-1:0] r);
      if (int'(r) >= NUM_PREGS) return 1'b1;
      return tbl[r];
   endfunction

   logic a_full, m_full, a_full_n, m_full_n;
   logic a_ok, m_ok, m_stop;
   logic [6:0] a_limit_n, m_limit_n;

   always_comb begin
      a_full = ({2'b0, acount_ff} >= {2'b0, alimit_ff})
               || (int'(acount_ff) >= ARITH_DEPTH);
      m_full = ({2'b0, mcount_ff} >= {2'b0, mlimit_ff})
               || (int'(mcount_ff) >= MEM_DEPTH);
      a_full_n = ({2'b0, acount_in} >= {2'b0, alimit_ff})
               || (int'(acount_in) >= ARITH_DEPTH);
      m_full_n = ({2'b0, mcount_in} >= {2'b0, mlimit_ff})
               || (int'(mcount_in) >= MEM_DEPTH);
      a_limit_n = ooo_ff ? 7'(acount_ff) : 7'd1;
      m_limit_n = ooo_ff ? 7'(mcount_ff) : 7'd1;
      a_ok = !(a_rd_data.masked && !rdy(ready_ff, a_rd_data.maskreg))
          && !(a_rd_data.nsrc >= 2'd2 && !a_rd_data.scalar
               && !rdy(ready_ff, a_rd_data.first))
          && !(a_rd_data.nsrc >= 2'd1 && !rdy(ready_ff, a_rd_data.second))
          && !(a_rd_data.nsrc == 2'd3 && !rdy(ready_ff, a_rd_data.third));
      m_ok = (!m_rd_data.store || rdy(ready_ff, m_rd_data.third))
          && (!m_rd_data.indexed || rdy(ready_ff, m_rd_data.second));
      m_stop = (pos_ff != 7'd0) && (m_rd_data.store || m_rd_data.indexed);
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      acount_in = acount_ff;
      mcount_in = mcount_ff;
      ready_in = ready_ff;
      pos_in = pos_ff;
      rd_wait_in = 1'b0;
      a_wr_en = 1'b0;
      m_wr_en = 1'b0;
      a_wr_addr = AIDX_W'(acount_ff);
      m_wr_addr = MIDX_W'(mcount_ff);
      a_wr_data = '{tag: req_ff.tag, first: req_ff.preg_first,
                    second: req_ff.preg_second, third: req_ff.preg_third,
                    maskreg: req_ff.preg_mask, masked: req_ff.is_masked,
                    scalar: req_ff.scalar_first, nsrc: req_ff.vector_sources};
      m_wr_data = '{tag: req_ff.tag, second: req_ff.preg_second,
                    third: req_ff.preg_third, store: req_ff.is_store,
                    indexed: req_ff.is_indexed};
      a_rd_addr = AIDX_W'(pos_ff);
      m_rd_addr = MIDX_W'(pos_ff);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               pos_in = '0;
               rd_wait_in = 1'b1;
               a_rd_addr = '0;
               m_rd_addr = '0;
               case (req_data.op)
                  OP_TICK: state_in = ST_ASCAN;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_ASCAN: begin
            // Read data is valid in the cycle after the address was set.
            if (!(acount_ff != '0 && req_ff.units_free[0])
                || pos_ff >= a_limit_n) begin
               state_in = ST_MSCAN;
               pos_in = '0;
               rd_wait_in = 1'b1;
               m_rd_addr = '0;
            end else if (rd_wait_ff) begin
               a_rd_addr = AIDX_W'(pos_ff);
            end else if (a_ok) begin
               rsp_in.arith_issued = 1'b1;
               rsp_in.arith_tag_out = a_rd_data.tag;
               pos_in = pos_ff + 7'd1;
               a_rd_addr = AIDX_W'(pos_ff + 7'd1);
               rd_wait_in = 1'b1;
               state_in = ST_AMOVE;
            end else begin
               pos_in = pos_ff + 7'd1;
               a_rd_addr = AIDX_W'(pos_ff + 7'd1);
               rd_wait_in = 1'b1;
            end
         end
         ST_AMOVE: begin
            // Copy entry pos down to pos-1 until the young end is reached.
            if (pos_ff >= 7'(acount_ff)) begin
               acount_in = acount_ff - 1'b1;
               state_in = ST_MSCAN;
               pos_in = '0;
               rd_wait_in = 1'b1;
               m_rd_addr = '0;
            end else if (rd_wait_ff) begin
               a_rd_addr = AIDX_W'(pos_ff);
            end else begin
               a_wr_en = 1'b1;
               a_wr_addr = AIDX_W'(pos_ff - 7'd1);
               a_wr_data = a_rd_data;
               pos_in = pos_ff + 7'd1;
               a_rd_addr = AIDX_W'(pos_ff + 7'd1);
               rd_wait_in = 1'b1;
            end
         end
         ST_MSCAN: begin
            if (!(mcount_ff != '0 && req_ff.units_free[1])
                || pos_ff >= m_limit_n) begin
               state_in = ST_DONE;
            end else if (rd_wait_ff) begin
               m_rd_addr = MIDX_W'(pos_ff);
            end else if (m_stop) begin
               state_in = ST_DONE;
            end else if (m_ok) begin
               rsp_in.mem_issued = 1'b1;
               rsp_in.mem_tag_out = m_rd_data.tag;
               pos_in = pos_ff + 7'd1;
               m_rd_addr = MIDX_W'(pos_ff + 7'd1);
               rd_wait_in = 1'b1;
               state_in = ST_MMOVE;
            end else begin
               pos_in = pos_ff + 7'd1;
               m_rd_addr = MIDX_W'(pos_ff + 7'd1);
               rd_wait_in = 1'b1;
            end
         end
         ST_MMOVE: begin
            if (pos_ff >= 7'(mcount_ff)) begin
               mcount_in = mcount_ff - 1'b1;
               state_in = ST_DONE;
            end else if (rd_wait_ff) begin
               m_rd_addr = MIDX_W'(pos_ff);
            end else begin
               m_wr_en = 1'b1;
               m_wr_addr = MIDX_W'(pos_ff - 7'd1);
               m_wr_data = m_rd_data;
               pos_in = pos_ff + 7'd1;
               m_rd_addr = MIDX_W'(pos_ff + 7'd1);
               rd_wait_in = 1'b1;
            end
         end
         ST_DONE: begin
            case (req_ff.op)
               OP_PUSH_ARITH: begin
                  if (a_full) rsp_in.push_dropped = 1'b1;
                  else begin
                     a_wr_en = 1'b1;
                     acount_in = acount_ff + 1'b1;
                  end
               end
               OP_PUSH_MEM: begin
                  if (m_full) rsp_in.push_dropped = 1'b1;
                  else begin
                     m_wr_en = 1'b1;
                     mcount_in = mcount_ff + 1'b1;
                  end
               end
               OP_MARK_READY, OP_MARK_BUSY: begin
                  if (int'(req_ff.preg_first) < NUM_PREGS) begin
                     ready_in[req_ff.preg_first] = (req_ff.op == OP_MARK_READY);
                  end
               end
               default: ;
            endcase
            rsp_in.arith_full = a_full_n;
            rsp_in.mem_full = m_full_n;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acount_ff <= '0;
         mcount_ff <= '0;
         ready_ff <= '1;
         ooo_ff <= 1'b1;
         alimit_ff <= CSR_DATA_W'(16);
         mlimit_ff <= CSR_DATA_W'(16);
         pos_ff <= '0;
         rd_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acount_ff <= acount_in;
         mcount_ff <= mcount_in;
         ready_ff <= ready_in;
         pos_ff <= pos_in;
         rd_wait_ff <= rd_wait_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_OOO_ENABLE:  ooo_ff <= csr_wr_data[0];
               CSR_ARITH_LIMIT: alimit_ff <= csr_wr_data;
               CSR_MEM_LIMIT:   mlimit_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(acount_ff) <= ARITH_DEPTH && int'(mcount_ff) <= MEM_DEPTH)
      else $error("queue count beyond depth");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in |-> state_ff == ST_DONE)
      else $error("response outside done state");
   a_issue_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AMOVE && pos_ff >= 7'(acount_ff)) |=>
      acount_ff == $past(acount_ff) - 1'b1)
      else $error("arith issue did not remove an entry");
endmodule
`default_nettype wire
